FILE: hw/rtl/qnlb_pkg.sv
`timescale 1ns / 1ps

package qnlb_pkg;

    // fixed-point formats
    localparam int FRAC_BITS = 14;
    localparam int POLY_BITS = 24;
    localparam int NUM_LANES = 4;

    localparam int COMP_W  = 16;                  // Q2.14 component
    localparam int FRAC_W  = 17;                  // Q1.16 blend fraction
    localparam int NEG_W   = COMP_W + 1;          // start after negation
    localparam int DIFF_W  = COMP_W + 2;          // target minus start
    localparam int MUL_W   = 2 * DIFF_W;          // fraction times difference
    localparam int LERP_W  = MUL_W + 1;           // lerp sum before rounding
    localparam int V_W     = COMP_W + 1;          // interpolated component
    localparam int DOT_W   = 2 * COMP_W;          // one dot product term
    localparam int DOTSUM_W = DOT_W + 2;
    localparam int SQ_W    = 2 * V_W - 3;         // v squared, at most 2^30
    localparam int LRAW_W  = SQ_W + 2;
    localparam int LEN_SH  = 2 * FRAC_BITS - POLY_BITS;
    localparam int LEN_W   = POLY_BITS + 5;       // Q24 squared length, up to 16.0
    localparam int COEF_W  = 24;
    localparam int PA_W    = COEF_W + LEN_W;
    localparam int U_W     = 31;
    localparam int PB_W    = U_W + LEN_W + 1;
    localparam int SCALE_W = 32;
    localparam int Q_W     = V_W + SCALE_W;
    localparam int QSH_W   = Q_W - POLY_BITS;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
    localparam logic signed [COMP_W-1:0] IDENT_W_VAL = COMP_W'(1 << FRAC_BITS);

    // polynomial for 1/sqrt(L), Q24
    localparam logic [LEN_W-1:0]          LEN_MAX = LEN_W'(64'd16 << POLY_BITS);
    localparam logic [LEN_W-1:0]          SPLIT   = LEN_W'(14378074);
    localparam logic [COEF_W-1:0]         LO_A    = COEF_W'(11733448);
    localparam logic [COEF_W-1:0]         HI_A    = COEF_W'(7617057);
    localparam logic signed [U_W-1:0]     LO_B    = U_W'(-30534281);
    localparam logic signed [U_W-1:0]     HI_B    = U_W'(-23547108);
    localparam logic signed [SCALE_W-1:0] LO_C    = SCALE_W'(35674552);
    localparam logic signed [SCALE_W-1:0] HI_C    = SCALE_W'(32707887);

    // pipeline stage positions
    localparam int ST_IN   = 0;
    localparam int ST_NEG  = 1;
    localparam int ST_MUL  = 2;
    localparam int ST_LERP = 3;
    localparam int ST_SQ   = 4;
    localparam int ST_LEN  = 5;
    localparam int ST_PA   = 6;
    localparam int ST_PU   = 7;
    localparam int ST_PB   = 8;
    localparam int ST_F    = 9;
    localparam int ST_SCL  = 10;
    localparam int ST_OUT  = 11;
    localparam int NUM_STAGES = 12;
    localparam int V_DLY   = ST_F - ST_LERP;

    typedef logic [NUM_STAGES-1:0] pipe_en_t;

    typedef struct packed {
        pipe_en_t en;
        logic     neg;
    } lane_ctl_t;

    typedef struct packed {
        logic                     command;
        logic signed [COMP_W-1:0] start_x;
        logic signed [COMP_W-1:0] start_y;
        logic signed [COMP_W-1:0] start_z;
        logic signed [COMP_W-1:0] start_w;
        logic signed [COMP_W-1:0] target_x;
        logic signed [COMP_W-1:0] target_y;
        logic signed [COMP_W-1:0] target_z;
        logic signed [COMP_W-1:0] target_w;
        logic [FRAC_W-1:0]        blend_fraction;
    } in_req_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic signed [COMP_W-1:0] out_w;
    } out_rsp_t;

endpackage

FILE: hw/rtl/quaternion_nlerp_blend.sv
`timescale 1ns / 1ps

// Quaternion normalized-lerp blend in Q2.14. Each request carries a start
// quaternion, a target quaternion (or the identity when command is set) and
// a Q1.16 blend fraction; the block flips the start when the dot product is
// negative, interpolates the four components, renormalizes with a quadratic
// approximation of 1/sqrt(length^2) and returns the saturated result. One
// request is taken every clock cycle while in_ready is high. The datapath is a
// 12-stage pipeline of four component lanes and one merge unit, each stage
// holding at most one multiplier. Bubbles are squeezed out under a stall, so
// in_ready drops only when all 12 stages hold a request and out_ready is low.
// The out_ready to in_ready path is combinational through the stage chain.
module quaternion_nlerp_blend
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qnlb_pkg::in_req_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output qnlb_pkg::out_rsp_t  out_data
);
    import qnlb_pkg::*;

    // stage occupancy and advance
    pipe_en_t valid_reg, valid_next;
    pipe_en_t adv;
    pipe_en_t en;
    pipe_en_t prev_valid;

    lane_ctl_t ctl;

    // per-lane request fields
    logic signed [COMP_W-1:0] start_arr  [NUM_LANES];
    logic signed [COMP_W-1:0] target_arr [NUM_LANES];
    logic signed [COMP_W-1:0] result_arr [NUM_LANES];
    logic signed [DOT_W-1:0]  dot_arr    [NUM_LANES];
    logic [SQ_W-1:0]          sq_arr     [NUM_LANES];

    logic [FRAC_W-1:0]        frac0_reg, frac0_next, frac1_reg;
    logic                     neg;
    logic signed [SCALE_W-1:0] scale;

    assign start_arr[0] = in_data.start_x;
    assign start_arr[1] = in_data.start_y;
    assign start_arr[2] = in_data.start_z;
    assign start_arr[3] = in_data.start_w;

    // identity target is (0, 0, 0, one)
    assign target_arr[0] = in_data.command ? '0 : in_data.target_x;
    assign target_arr[1] = in_data.command ? '0 : in_data.target_y;
    assign target_arr[2] = in_data.command ? '0 : in_data.target_z;
    assign target_arr[3] = in_data.command ? IDENT_W_VAL : in_data.target_w;

    // fraction above one is held at one
    assign frac0_next = (in_data.blend_fraction > FRAC_ONE) ? FRAC_ONE
                                                           : in_data.blend_fraction;

    // a stage may load when it and every stage after it is not all full,
    // or when the output is being drained
    always_comb
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            adv[k] = out_ready || !(&(valid_reg | pipe_en_t'((64'd1 << k) - 1)));
        end
    end

    assign prev_valid = {valid_reg[NUM_STAGES-2:0], in_valid};
    assign en         = adv & prev_valid;
    assign valid_next = (adv & prev_valid) | (~adv & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // fraction travels with the request until the multiply stage
    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            frac0_reg <= frac0_next;
        end
        if (en[ST_NEG])
        begin
            frac1_reg <= frac0_reg;
        end
    end

    assign ctl.en  = en;
    assign ctl.neg = neg;

    // one lane per component
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        qnlb_lane u_lane
        (
            .clk      (clk),
            .ctl      (ctl),
            .start    (start_arr[i]),
            .target   (target_arr[i]),
            .frac     (frac1_reg),
            .scale    (scale),
            .dot_term (dot_arr[i]),
            .sq       (sq_arr[i]),
            .result   (result_arr[i])
        );
    end

    // dot product sign, squared length and 1/sqrt polynomial
    qnlb_merge u_merge
    (
        .clk      (clk),
        .en       (en),
        .dot_term (dot_arr),
        .sq       (sq_arr),
        .neg      (neg),
        .scale    (scale)
    );

    assign in_ready       = adv[ST_IN];
    assign out_valid      = valid_reg[ST_OUT];
    assign out_data.out_x = result_arr[0];
    assign out_data.out_y = result_arr[1];
    assign out_data.out_z = result_arr[2];
    assign out_data.out_w = result_arr[3];

    // a request is refused only when the whole pipeline is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg))
        else $error("request refused with an empty stage");

    // the renormalizing factor is always positive for a live request
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_SCL] |-> !scale[SCALE_W-1])
        else $error("negative renormalizing factor");

    // a result appears only after the scaling stage held a request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(valid_reg[ST_SCL]))
        else $error("result without a scaled request");

endmodule

FILE: hw/rtl/qnlb_lane.sv
`timescale 1ns / 1ps

module qnlb_lane
(
    input  logic                                  clk,
    input  qnlb_pkg::lane_ctl_t                   ctl,
    input  logic signed [qnlb_pkg::COMP_W-1:0]    start,
    input  logic signed [qnlb_pkg::COMP_W-1:0]    target,
    input  logic [qnlb_pkg::FRAC_W-1:0]           frac,
    input  logic signed [qnlb_pkg::SCALE_W-1:0]   scale,
    output logic signed [qnlb_pkg::DOT_W-1:0]     dot_term,
    output logic [qnlb_pkg::SQ_W-1:0]             sq,
    output logic signed [qnlb_pkg::COMP_W-1:0]    result
);
    import qnlb_pkg::*;

    logic signed [COMP_W-1:0] s0_reg, t0_reg;
    logic signed [DOT_W-1:0]  dot_reg, dot_next;
    logic signed [NEG_W-1:0]  s1_reg, s1_next, s2_reg;
    logic signed [DIFF_W-1:0] d1_reg, d1_next;
    logic signed [MUL_W-1:0]  m2_reg, m2_next;
    logic signed [LERP_W-1:0] lerp_sum;
    logic signed [V_W-1:0]    v3_reg;
    logic signed [2*V_W-1:0]  sq_full;
    logic [SQ_W-1:0]          sq_reg;
    logic signed [V_W-1:0]    v_dly_reg [V_DLY];
    logic signed [Q_W-1:0]    q_reg, q_next, q_rnd;
    logic signed [QSH_W-1:0]  q_sh;
    logic signed [COMP_W-1:0] res_reg, res_next;
    logic signed [NEG_W-1:0]  s0_ext;
    logic signed [DIFF_W-1:0] s0_wide, t0_wide;
    logic signed [DIFF_W-1:0] frac_s;

    assign dot_next = DOT_W'(start * target);

    // negate start when the dot product is negative
    assign s0_ext  = NEG_W'(s0_reg);
    assign s0_wide = DIFF_W'(s0_reg);
    assign t0_wide = DIFF_W'(t0_reg);
    assign s1_next = ctl.neg ? -s0_ext : s0_ext;
    assign d1_next = ctl.neg ? (t0_wide + s0_wide) : (t0_wide - s0_wide);

    assign frac_s  = $signed({1'b0, frac});
    assign m2_next = MUL_W'(frac_s * d1_reg);

    // s*65536 + T*(t-s), rounded back by 16 bits
    assign lerp_sum = ($signed(LERP_W'(s2_reg)) <<< 16) + LERP_W'(m2_reg)
                    + LERP_W'(32768);

    assign sq_full = v3_reg * v3_reg;

    assign q_next = Q_W'(v_dly_reg[V_DLY-1] * scale);
    assign q_rnd  = q_reg + Q_W'(64'd1 << (POLY_BITS - 1));
    assign q_sh   = q_rnd[Q_W-1:POLY_BITS];

    // saturate: fits when the top bits all match the sign
    always_comb
    begin
        if (!q_sh[QSH_W-1] && (|q_sh[QSH_W-2:COMP_W-1]))
        begin
            res_next = {1'b0, {(COMP_W-1){1'b1}}};
        end
        else if (q_sh[QSH_W-1] && !(&q_sh[QSH_W-2:COMP_W-1]))
        begin
            res_next = {1'b1, {(COMP_W-1){1'b0}}};
        end
        else
        begin
            res_next = q_sh[COMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_IN])
        begin
            s0_reg  <= start;
            t0_reg  <= target;
            dot_reg <= dot_next;
        end
        if (ctl.en[ST_NEG])
        begin
            s1_reg <= s1_next;
            d1_reg <= d1_next;
        end
        if (ctl.en[ST_MUL])
        begin
            s2_reg <= s1_reg;
            m2_reg <= m2_next;
        end
        if (ctl.en[ST_LERP])
        begin
            v3_reg <= lerp_sum[V_W+15:16];
        end
        if (ctl.en[ST_SQ])
        begin
            sq_reg       <= sq_full[SQ_W-1:0];
            v_dly_reg[0] <= v3_reg;
        end
        for (int k = 1; k < V_DLY; k++)
        begin
            if (ctl.en[ST_SQ + k])
            begin
                v_dly_reg[k] <= v_dly_reg[k-1];
            end
        end
        if (ctl.en[ST_SCL])
        begin
            q_reg <= q_next;
        end
        if (ctl.en[ST_OUT])
        begin
            res_reg <= res_next;
        end
    end

    assign dot_term = dot_reg;
    assign sq       = sq_reg;
    assign result   = res_reg;

endmodule

FILE: hw/rtl/qnlb_merge.sv
`timescale 1ns / 1ps

module qnlb_merge
(
    input  logic                                 clk,
    input  qnlb_pkg::pipe_en_t                   en,
    input  logic signed [qnlb_pkg::DOT_W-1:0]    dot_term [qnlb_pkg::NUM_LANES],
    input  logic [qnlb_pkg::SQ_W-1:0]            sq [qnlb_pkg::NUM_LANES],
    output logic                                 neg,
    output logic signed [qnlb_pkg::SCALE_W-1:0]  scale
);
    import qnlb_pkg::*;

    logic signed [DOTSUM_W-1:0] dot_sum;
    logic [LRAW_W-1:0]          lraw, lraw_rnd;
    logic [LEN_W-1:0]           len_shr;
    logic [LEN_W-1:0]           len5_reg, len5_next, len6_reg, len7_reg;
    logic                       hi6_reg, hi6_next, hi7_reg, hi8_reg;
    logic [COEF_W-1:0]          coef_a;
    logic [PA_W-1:0]            pa_reg, pa_next, pa_rnd;
    logic signed [U_W-1:0]      u_reg, u_next;
    logic signed [PB_W-1:0]     pb_reg, pb_next, pb_rnd;
    logic signed [SCALE_W-1:0]  f_reg, f_next;

    always_comb
    begin
        dot_sum = '0;
        lraw    = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            dot_sum = dot_sum + DOTSUM_W'(dot_term[i]);
            lraw    = lraw + LRAW_W'(sq[i]);
        end
    end

    assign neg = dot_sum[DOTSUM_W-1];

    // squared length to Q24, clamped to 16.0
    assign lraw_rnd  = lraw + LRAW_W'(64'd1 << (LEN_SH - 1));
    assign len_shr   = LEN_W'(lraw_rnd >> LEN_SH);
    assign len5_next = (len_shr > LEN_MAX) ? LEN_MAX : len_shr;

    assign hi6_next = (len5_reg >= SPLIT);
    assign coef_a   = hi6_next ? HI_A : LO_A;
    assign pa_next  = PA_W'(coef_a) * PA_W'(len5_reg);

    assign pa_rnd = pa_reg + PA_W'(64'd1 << (POLY_BITS - 1));
    assign u_next = $signed(U_W'(pa_rnd >> POLY_BITS)) + (hi6_reg ? HI_B : LO_B);

    assign pb_next = PB_W'(u_reg) * $signed(PB_W'({1'b0, len7_reg}));

    assign pb_rnd = pb_reg + PB_W'(64'd1 << (POLY_BITS - 1));
    assign f_next = pb_rnd[POLY_BITS+SCALE_W-1:POLY_BITS] + (hi8_reg ? HI_C : LO_C);

    always_ff @(posedge clk)
    begin
        if (en[ST_LEN])
        begin
            len5_reg <= len5_next;
        end
        if (en[ST_PA])
        begin
            len6_reg <= len5_reg;
            hi6_reg  <= hi6_next;
            pa_reg   <= pa_next;
        end
        if (en[ST_PU])
        begin
            len7_reg <= len6_reg;
            hi7_reg  <= hi6_reg;
            u_reg    <= u_next;
        end
        if (en[ST_PB])
        begin
            hi8_reg <= hi7_reg;
            pb_reg  <= pb_next;
        end
        if (en[ST_F])
        begin
            f_reg <= f_next;
        end
    end

    assign scale = f_reg;

endmodule
